// ----- rtl/bsc_pkg.sv -----
// Shared types, codes and field widths of the Banker's safety check block.
package bsc_pkg;

   localparam int MODE_W   = 3;
   localparam int PROC_W   = 3;
   localparam int RES_W    = 2;
   localparam int AMT_W    = 8;
   localparam int STATUS_W = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD_MAX   = 3'd0,
      MODE_LOAD_ALLOC = 3'd1,
      MODE_LOAD_AVAIL = 3'd2,
      MODE_STAGE      = 3'd3,
      MODE_EVAL       = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_LOADED     = 3'd0,
      STATUS_GRANTED    = 3'd1,
      STATUS_UNSAFE     = 3'd2,
      STATUS_OVER_NEED  = 3'd3,
      STATUS_OVER_AVAIL = 3'd4
   } status_type;

   typedef struct packed {
      logic wr_max;
      logic wr_alloc;
   } tbl_ctl_type;

endpackage

// ----- rtl/bsc_if.sv -----
// Request and response channel interfaces of the Banker's safety check block.
interface bsc_req_if import bsc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [PROC_W-1:0]   process_index;
   logic [RES_W-1:0]    resource_index;
   logic [AMT_W-1:0]    amount;

   modport source (output valid, mode, process_index, resource_index, amount, input ready);
   modport sink (input valid, mode, process_index, resource_index, amount, output ready);
endinterface

interface bsc_rsp_if import bsc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;

   modport source (output valid, status, input ready);
   modport sink (input valid, status, output ready);
endinterface

// ----- rtl/bankers_safety_check.sv -----
// Banker's algorithm request check: table loads, request staging and safety scan.
// Loads and stages: the done state registers the response valid, then the sequencer idles.
// Evaluate: a check pass over the resources, then scan passes that skip finished processes,
//   test each other process resource by resource and add the allocation of a fitting one
//   to the work vector, then a commit pass over the resources and the response.
// One transaction at a time; ready only while idle; an untaken response holds the sequencer.
// Reset: zeroing pass over 2^(clog2 PROC_COUNT + clog2 RES_COUNT) table entries (32 by default).
module bankers_safety_check import bsc_pkg::*; #(
   parameter int PROC_COUNT = 8,
   parameter int RES_COUNT  = 4,
   parameter int COUNT_BITS = 8
) (
   input logic         clock,
   input logic         reset,
   bsc_req_if.sink     req_chan,
   bsc_rsp_if.source   rsp_chan
);

   localparam int PB = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
   localparam int RB = (RES_COUNT > 1) ? $clog2(RES_COUNT) : 1;
   localparam int AW = PB + RB;
   localparam int WW = COUNT_BITS + $clog2(PROC_COUNT + 2);
   localparam int AB = COUNT_BITS + 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_FIT,
      S_ADD,
      S_COMMIT,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [PB-1:0]          p_ff, p_in;
   logic [RB-1:0]          r_ff, r_in;
   logic [PB-1:0]          proc_ff, proc_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [PROC_COUNT-1:0]  fin_ff, fin_in;
   logic                   prog_ff, prog_in;
   logic                   fit_ff, fit_in;
   logic                   over_need_ff, over_need_in;
   logic                   over_avail_ff, over_avail_in;
   status_type             status_ff, status_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0]  avail_ff  [RES_COUNT];
   logic [COUNT_BITS-1:0]  avail_in  [RES_COUNT];
   logic [COUNT_BITS-1:0]  staged_ff [RES_COUNT];
   logic [COUNT_BITS-1:0]  staged_in [RES_COUNT];
   logic [WW-1:0]          work_ff   [RES_COUNT];
   logic [WW-1:0]          work_in   [RES_COUNT];
   logic [AB-1:0]          abuf_ff   [RES_COUNT];
   logic [AB-1:0]          abuf_in   [RES_COUNT];

   tbl_ctl_type            tbl_ctl;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   logic [COUNT_BITS-1:0]  wr_max_data;
   logic [COUNT_BITS-1:0]  wr_alloc_data;
   logic [COUNT_BITS-1:0]  max_rd;
   logic [COUNT_BITS-1:0]  alloc_rd;

   logic                   accept;
   logic                   out_free;
   logic                   p_ok;
   logic                   r_ok;
   logic [PB-1:0]          req_p;
   logic [RB-1:0]          req_r;
   logic [COUNT_BITS-1:0]  req_amt;
   logic                   last_r;
   logic                   last_p;
   logic                   is_proc;
   logic [COUNT_BITS-1:0]  cur_staged;
   logic [COUNT_BITS-1:0]  cur_avail;
   logic [WW-1:0]          cur_work;
   logic [COUNT_BITS-1:0]  need;
   logic [COUNT_BITS-1:0]  nd;
   logic                   fits_now;
   logic                   adv_p;

   bsc_tables #(
      .ADDR_BITS (AW),
      .DATA_BITS (COUNT_BITS)
   ) u_tables (
      .clock         (clock),
      .ctl           (tbl_ctl),
      .wr_addr       (wr_addr),
      .wr_max_data   (wr_max_data),
      .wr_alloc_data (wr_alloc_data),
      .rd_addr       (rd_addr),
      .max_rd        (max_rd),
      .alloc_rd      (alloc_rd)
   );

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign p_ok     = int'(req_chan.process_index) < PROC_COUNT;
   assign r_ok     = int'(req_chan.resource_index) < RES_COUNT;
   assign req_p    = PB'(req_chan.process_index);
   assign req_r    = RB'(req_chan.resource_index);
   assign req_amt  = COUNT_BITS'(req_chan.amount);

   assign last_r     = r_ff == RB'(RES_COUNT - 1);
   assign last_p     = p_ff == PB'(PROC_COUNT - 1);
   assign is_proc    = p_ff == proc_ff;
   assign cur_staged = staged_ff[r_ff];
   assign cur_avail  = avail_ff[r_ff];
   assign cur_work   = work_ff[r_ff];
   assign need       = (max_rd > alloc_rd) ? (max_rd - alloc_rd) : '0;
   assign nd         = is_proc ? (need - cur_staged) : need;
   assign fits_now   = WW'(nd) <= cur_work;

   always_comb begin
      state_in      = state_ff;
      p_in          = p_ff;
      r_in          = r_ff;
      proc_in       = proc_ff;
      clr_in        = clr_ff;
      fin_in        = fin_ff;
      prog_in       = prog_ff;
      fit_in        = fit_ff;
      over_need_in  = over_need_ff;
      over_avail_in = over_avail_ff;
      status_in     = status_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      avail_in      = avail_ff;
      staged_in     = staged_ff;
      work_in       = work_ff;
      abuf_in       = abuf_ff;
      tbl_ctl       = '0;
      wr_addr       = {p_ff, r_ff};
      wr_max_data   = req_amt;
      wr_alloc_data = req_amt;
      adv_p         = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            tbl_ctl.wr_max   = 1'b1;
            tbl_ctl.wr_alloc = 1'b1;
            wr_addr          = clr_ff;
            wr_max_data      = '0;
            wr_alloc_data    = '0;
            clr_in           = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               status_in = STATUS_LOADED;
               state_in  = S_DONE;
               wr_addr   = {req_p, req_r};
               unique case (req_chan.mode)
                  MODE_LOAD_MAX: begin
                     tbl_ctl.wr_max = p_ok && r_ok;
                  end
                  MODE_LOAD_ALLOC: begin
                     tbl_ctl.wr_alloc = p_ok && r_ok;
                  end
                  MODE_LOAD_AVAIL: begin
                     if (r_ok) begin
                        avail_in[req_r] = req_amt;
                     end
                  end
                  MODE_STAGE: begin
                     if (r_ok) begin
                        staged_in[req_r] = req_amt;
                     end
                  end
                  MODE_EVAL: begin
                     if (p_ok) begin
                        state_in      = S_CHECK;
                        proc_in       = req_p;
                        p_in          = req_p;
                        r_in          = '0;
                        over_need_in  = 1'b0;
                        over_avail_in = 1'b0;
                     end else begin
                        status_in = STATUS_OVER_NEED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CHECK: begin
            over_need_in     = over_need_ff || (cur_staged > need);
            over_avail_in    = over_avail_ff || (cur_staged > cur_avail);
            work_in[r_ff]    = WW'(cur_avail) - WW'(cur_staged);
            if (last_r) begin
               priority if (over_need_in) begin
                  status_in = STATUS_OVER_NEED;
                  state_in  = S_DONE;
               end else if (over_avail_in) begin
                  status_in = STATUS_OVER_AVAIL;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_FIT;
                  p_in     = '0;
                  r_in     = '0;
                  fin_in   = '0;
                  prog_in  = 1'b0;
                  fit_in   = 1'b1;
               end
            end else begin
               r_in = r_ff + RB'(1);
            end
         end
         S_FIT: begin
            abuf_in[r_ff] = AB'(alloc_rd) + (is_proc ? AB'(cur_staged) : AB'(0));
            priority if (fin_ff[p_ff]) begin
               adv_p = 1'b1;
            end else if (last_r) begin
               if (fit_ff && fits_now) begin
                  fin_in[p_ff] = 1'b1;
                  prog_in      = 1'b1;
                  state_in     = S_ADD;
                  r_in         = '0;
               end else begin
                  adv_p = 1'b1;
               end
            end else begin
               fit_in = fit_ff && fits_now;
               r_in   = r_ff + RB'(1);
            end
         end
         S_ADD: begin
            work_in[r_ff] = cur_work + WW'(abuf_ff[r_ff]);
            if (last_r) begin
               adv_p = 1'b1;
            end else begin
               r_in = r_ff + RB'(1);
            end
         end
         S_COMMIT: begin
            tbl_ctl.wr_alloc = 1'b1;
            wr_alloc_data    = alloc_rd + cur_staged;
            avail_in[r_ff]   = cur_avail - cur_staged;
            if (last_r) begin
               status_in = STATUS_GRANTED;
               state_in  = S_DONE;
            end else begin
               r_in = r_ff + RB'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_vld_in    = 1'b1;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (adv_p) begin
         priority if (!last_p) begin
            p_in     = p_ff + PB'(1);
            r_in     = '0;
            fit_in   = 1'b1;
            state_in = S_FIT;
         end else if (&fin_ff) begin
            p_in     = proc_ff;
            r_in     = '0;
            state_in = S_COMMIT;
         end else if (!prog_ff) begin
            status_in = STATUS_UNSAFE;
            state_in  = S_DONE;
         end else begin
            p_in     = '0;
            r_in     = '0;
            prog_in  = 1'b0;
            fit_in   = 1'b1;
            state_in = S_FIT;
         end
      end

      rd_addr = {p_in, r_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         rsp_vld_ff <= 1'b0;
         fin_ff     <= '0;
         avail_ff   <= '{default: '0};
         staged_ff  <= '{default: '0};
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         rsp_vld_ff <= rsp_vld_in;
         fin_ff     <= fin_in;
         avail_ff   <= avail_in;
         staged_ff  <= staged_in;
      end
      p_ff          <= p_in;
      r_ff          <= r_in;
      proc_ff       <= proc_in;
      prog_ff       <= prog_in;
      fit_ff        <= fit_in;
      over_need_ff  <= over_need_in;
      over_avail_ff <= over_avail_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      work_ff       <= work_in;
      abuf_ff       <= abuf_in;
   end

   assign req_chan.ready  = state_ff == S_IDLE;
   assign rsp_chan.valid  = rsp_vld_ff;
   assign rsp_chan.status = rsp_status_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted transaction left sequencer idle");

   a_commit_all_finished: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMMIT |-> &fin_ff)
      else $error("commit without every process finished");

   a_add_marked: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADD |-> fin_ff[p_ff] && prog_ff)
      else $error("work update for an unmarked process");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the done state");
`endif

endmodule

// ----- rtl/bsc_tables.sv -----
// Maximum-claim and allocation memories with one write port and a registered read.
module bsc_tables import bsc_pkg::*; #(
   parameter int ADDR_BITS = 5,
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  tbl_ctl_type          ctl,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_max_data,
   input  logic [DATA_BITS-1:0] wr_alloc_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] max_rd,
   output logic [DATA_BITS-1:0] alloc_rd
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] max_mem   [DEPTH];
   logic [DATA_BITS-1:0] alloc_mem [DEPTH];
   logic [DATA_BITS-1:0] max_rd_ff;
   logic [DATA_BITS-1:0] alloc_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_max) begin
         max_mem[wr_addr] <= wr_max_data;
      end
      max_rd_ff <= max_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_alloc) begin
         alloc_mem[wr_addr] <= wr_alloc_data;
      end
      alloc_rd_ff <= alloc_mem[rd_addr];
   end

   assign max_rd   = max_rd_ff;
   assign alloc_rd = alloc_rd_ff;

endmodule
